// ===== hdl/lsps_pkg.sv =====
// shared constants for the line segment point sampler
`timescale 1ns / 1ps

package lsps_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int IVL_W   = 16;
  localparam int PITCH_W = 8;

  localparam logic [IVL_W-1:0]   IVL_RST   = 16'd100;
  localparam logic [PITCH_W-1:0] PITCH_RST = 8'd25;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_PITCH     = 1'b1;

endpackage

// ===== hdl/lsps_queue.sv =====
// small register queue between the front and back sections
`timescale 1ns / 1ps

module lsps_queue
  import lsps_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNW-1:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTW'(DEPTH - 1)) ? '0 : wr_ptr_r + PTW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTW'(DEPTH - 1)) ? '0 : rd_ptr_r + PTW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // front must hold its record while the queue is full
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push while queue full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNW'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== hdl/lsps_front.sv =====
// front section: takes segments, finds the jump count and the per-point steps
`timescale 1ns / 1ps

module lsps_front
  import lsps_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int CW    = $clog2(MAX_POINTS + 1),
  localparam int AW    = COORD_BITS + FRAC_BITS + 1,
  localparam int REC_W = 2 + CW + 4 * COORD_BITS + 2 * AW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  input  logic [IVL_W-1:0]      sample_interval,
  input  logic [PITCH_W-1:0]    pixel_pitch,
  output logic                  q_push,
  input  logic                  q_full,
  output logic [REC_W-1:0]      q_wdata
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int SQW  = 2 * C;
  localparam int D2W  = SQW + 1;
  localparam int P2W  = 2 * PITCH_W;
  localparam int TW   = D2W + P2W;
  localparam int JW   = $clog2(MAX_POINTS + 2);
  localparam int BW   = $clog2(JW);
  localparam int PW   = JW + IVL_W;
  localparam int SW   = 2 * PW;
  localparam int CMPW = (SW > TW) ? SW : TW;
  localparam int NW   = C + F;
  localparam int DCW  = $clog2(NW);

  typedef struct packed {
    logic                 short_seg;
    logic                 clamped;
    logic [CW-1:0]        cnt;
    logic [C-1:0]         sx;
    logic [C-1:0]         sy;
    logic [C-1:0]         ex;
    logic [C-1:0]         ey;
    logic signed [AW-1:0] stepx;
    logic signed [AW-1:0] stepy;
  } seg_rec_t;

  typedef enum logic [10:0] {
    F_IDLE = 11'b00000000001,
    F_DIFF = 11'b00000000010,
    F_SQ   = 11'b00000000100,
    F_SUM  = 11'b00000001000,
    F_TGT  = 11'b00000010000,
    F_MUL1 = 11'b00000100000,
    F_MUL2 = 11'b00001000000,
    F_CMP  = 11'b00010000000,
    F_FIN  = 11'b00100000000,
    F_DIV  = 11'b01000000000,
    F_PUSH = 11'b10000000000
  } fstate_t;

  fstate_t        state_r, state_nxt;
  logic [C-1:0]   sx_r, sx_nxt, sy_r, sy_nxt, ex_r, ex_nxt, ey_r, ey_nxt;
  logic [C-1:0]   adx_r, adx_nxt, ady_r, ady_nxt;
  logic           negx_r, negx_nxt, negy_r, negy_nxt;
  logic [SQW-1:0] dxx_r, dxx_nxt, dyy_r, dyy_nxt;
  logic [P2W-1:0] p2_r, p2_nxt;
  logic [D2W-1:0] d2_r, d2_nxt;
  logic [TW-1:0]  tgt_r, tgt_nxt;
  logic [JW-1:0]  j_r, j_nxt;
  logic [BW-1:0]  bidx_r, bidx_nxt;
  logic [PW-1:0]  prod_r, prod_nxt;
  logic           candok_r, candok_nxt;
  logic [SW-1:0]  sq_r, sq_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           short_r, short_nxt;
  logic           clamped_r, clamped_nxt;
  logic [NW-1:0]  qx_r, qx_nxt, qy_r, qy_nxt;
  logic [CW-1:0]  remx_r, remx_nxt, remy_r, remy_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;

  logic [JW-1:0]        cand;
  logic [CW:0]          shx, shy, dvs;
  logic                 gex, gey;
  logic signed [AW-1:0] magx, magy;
  seg_rec_t             rec;

  assign in_full = (state_r != F_IDLE);
  assign q_push  = (state_r == F_PUSH) && !q_full;
  assign cand    = j_r | (JW'(1) << bidx_r);

  // one restoring division step for each axis
  assign dvs = {1'b0, cnt_r};
  assign shx = {remx_r, qx_r[NW-1]};
  assign shy = {remy_r, qy_r[NW-1]};
  assign gex = (shx >= dvs);
  assign gey = (shy >= dvs);

  assign magx = AW'(qx_r);
  assign magy = AW'(qy_r);

  always_comb begin
    rec.short_seg = short_r;
    rec.clamped   = clamped_r;
    rec.cnt       = cnt_r;
    rec.sx        = sx_r;
    rec.sy        = sy_r;
    rec.ex        = ex_r;
    rec.ey        = ey_r;
    rec.stepx     = negx_r ? -magx : magx;
    rec.stepy     = negy_r ? -magy : magy;
  end

  assign q_wdata = rec;

  always_comb begin
    state_nxt   = state_r;
    sx_nxt      = sx_r;
    sy_nxt      = sy_r;
    ex_nxt      = ex_r;
    ey_nxt      = ey_r;
    adx_nxt     = adx_r;
    ady_nxt     = ady_r;
    negx_nxt    = negx_r;
    negy_nxt    = negy_r;
    dxx_nxt     = dxx_r;
    dyy_nxt     = dyy_r;
    p2_nxt      = p2_r;
    d2_nxt      = d2_r;
    tgt_nxt     = tgt_r;
    j_nxt       = j_r;
    bidx_nxt    = bidx_r;
    prod_nxt    = prod_r;
    candok_nxt  = candok_r;
    sq_nxt      = sq_r;
    cnt_nxt     = cnt_r;
    short_nxt   = short_r;
    clamped_nxt = clamped_r;
    qx_nxt      = qx_r;
    qy_nxt      = qy_r;
    remx_nxt    = remx_r;
    remy_nxt    = remy_r;
    dcnt_nxt    = dcnt_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_push) begin
          sx_nxt    = in_start_x;
          sy_nxt    = in_start_y;
          ex_nxt    = in_end_x;
          ey_nxt    = in_end_y;
          state_nxt = F_DIFF;
        end
      end
      F_DIFF: begin
        negx_nxt  = (ex_r < sx_r);
        negy_nxt  = (ey_r < sy_r);
        adx_nxt   = (ex_r < sx_r) ? sx_r - ex_r : ex_r - sx_r;
        ady_nxt   = (ey_r < sy_r) ? sy_r - ey_r : ey_r - sy_r;
        state_nxt = F_SQ;
      end
      F_SQ: begin
        dxx_nxt   = SQW'(adx_r) * SQW'(adx_r);
        dyy_nxt   = SQW'(ady_r) * SQW'(ady_r);
        p2_nxt    = P2W'(pixel_pitch) * P2W'(pixel_pitch);
        state_nxt = F_SUM;
      end
      F_SUM: begin
        d2_nxt    = D2W'(dxx_r) + D2W'(dyy_r);
        state_nxt = F_TGT;
      end
      F_TGT: begin
        tgt_nxt   = TW'(d2_r) * TW'(p2_r);
        j_nxt     = '0;
        bidx_nxt  = BW'(JW - 1);
        state_nxt = F_MUL1;
      end
      F_MUL1: begin
        prod_nxt   = PW'(cand) * PW'(sample_interval);
        candok_nxt = (cand <= JW'(MAX_POINTS + 1));
        state_nxt  = F_MUL2;
      end
      F_MUL2: begin
        sq_nxt    = SW'(prod_r) * SW'(prod_r);
        state_nxt = F_CMP;
      end
      F_CMP: begin
        if (candok_r && (CMPW'(sq_r) <= CMPW'(tgt_r))) begin
          j_nxt = cand;
        end
        if (bidx_r == '0) begin
          state_nxt = F_FIN;
        end else begin
          bidx_nxt  = bidx_r - BW'(1);
          state_nxt = F_MUL1;
        end
      end
      F_FIN: begin
        qx_nxt   = {adx_r, {F{1'b0}}};
        qy_nxt   = {ady_r, {F{1'b0}}};
        remx_nxt = '0;
        remy_nxt = '0;
        dcnt_nxt = DCW'(NW - 1);
        priority if (j_r == '0) begin
          short_nxt   = 1'b1;
          clamped_nxt = 1'b0;
          cnt_nxt     = CW'(2);
          state_nxt   = F_PUSH;
        end else if (j_r > JW'(MAX_POINTS)) begin
          short_nxt   = 1'b0;
          clamped_nxt = 1'b1;
          cnt_nxt     = CW'(MAX_POINTS);
          state_nxt   = F_DIV;
        end else begin
          short_nxt   = 1'b0;
          clamped_nxt = 1'b0;
          cnt_nxt     = CW'(j_r);
          state_nxt   = F_DIV;
        end
      end
      F_DIV: begin
        remx_nxt = gex ? CW'(shx - dvs) : shx[CW-1:0];
        remy_nxt = gey ? CW'(shy - dvs) : shy[CW-1:0];
        qx_nxt   = {qx_r[NW-2:0], gex};
        qy_nxt   = {qy_r[NW-2:0], gey};
        if (dcnt_r == '0) begin
          state_nxt = F_PUSH;
        end else begin
          dcnt_nxt = dcnt_r - DCW'(1);
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    ex_r      <= ex_nxt;
    ey_r      <= ey_nxt;
    adx_r     <= adx_nxt;
    ady_r     <= ady_nxt;
    negx_r    <= negx_nxt;
    negy_r    <= negy_nxt;
    dxx_r     <= dxx_nxt;
    dyy_r     <= dyy_nxt;
    p2_r      <= p2_nxt;
    d2_r      <= d2_nxt;
    tgt_r     <= tgt_nxt;
    j_r       <= j_nxt;
    bidx_r    <= bidx_nxt;
    prod_r    <= prod_nxt;
    candok_r  <= candok_nxt;
    sq_r      <= sq_nxt;
    cnt_r     <= cnt_nxt;
    short_r   <= short_nxt;
    clamped_r <= clamped_nxt;
    qx_r      <= qx_nxt;
    qy_r      <= qy_nxt;
    remx_r    <= remx_nxt;
    remy_r    <= remy_nxt;
    dcnt_r    <= dcnt_nxt;
  end

  // a record leaves only with a count in range
  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (cnt_r != '0) && (cnt_r <= CW'(MAX_POINTS)))
    else $error("record count out of range");

endmodule

// ===== hdl/lsps_back.sv =====
// back section: steps the accumulators and drives the result register
`timescale 1ns / 1ps

module lsps_back
  import lsps_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int CW    = $clog2(MAX_POINTS + 1),
  localparam int AW    = COORD_BITS + FRAC_BITS + 1,
  localparam int REC_W = 2 + CW + 4 * COORD_BITS + 2 * AW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [REC_W-1:0]      q_rdata,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [COORD_BITS-1:0] out_point_x,
  output logic [COORD_BITS-1:0] out_point_y,
  output logic                  out_last_point,
  output logic                  out_count_clamped
);

  localparam int C = COORD_BITS;
  localparam int F = FRAC_BITS;

  typedef struct packed {
    logic                 short_seg;
    logic                 clamped;
    logic [CW-1:0]        cnt;
    logic [C-1:0]         sx;
    logic [C-1:0]         sy;
    logic [C-1:0]         ex;
    logic [C-1:0]         ey;
    logic signed [AW-1:0] stepx;
    logic signed [AW-1:0] stepy;
  } seg_rec_t;

  seg_rec_t             rec;
  logic                 busy_r, busy_nxt;
  logic                 short_r, short_nxt;
  logic                 clamped_r, clamped_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic signed [AW-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic signed [AW-1:0] stepx_r, stepx_nxt, stepy_r, stepy_nxt;
  logic [C-1:0]         ex_r, ex_nxt, ey_r, ey_nxt;
  logic                 oval_r, oval_nxt;
  logic [C-1:0]         px_r, px_nxt, py_r, py_nxt;
  logic                 last_r, last_nxt;
  logic                 oclmp_r, oclmp_nxt;
  logic                 load, emit, is_last;

  assign rec     = q_rdata;
  assign load    = !busy_r && !q_empty;
  assign emit    = busy_r && (!oval_r || out_pop);
  assign is_last = (k_r == cnt_r - CW'(1));
  assign q_pop   = load;

  assign out_empty         = !oval_r;
  assign out_point_x       = px_r;
  assign out_point_y       = py_r;
  assign out_last_point    = last_r;
  assign out_count_clamped = oclmp_r;

  always_comb begin
    busy_nxt    = busy_r;
    short_nxt   = short_r;
    clamped_nxt = clamped_r;
    cnt_nxt     = cnt_r;
    k_nxt       = k_r;
    ax_nxt      = ax_r;
    ay_nxt      = ay_r;
    stepx_nxt   = stepx_r;
    stepy_nxt   = stepy_r;
    ex_nxt      = ex_r;
    ey_nxt      = ey_r;
    oval_nxt    = oval_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    last_nxt    = last_r;
    oclmp_nxt   = oclmp_r;
    if (oval_r && out_pop) begin
      oval_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt    = 1'b1;
      short_nxt   = rec.short_seg;
      clamped_nxt = rec.clamped;
      cnt_nxt     = rec.cnt;
      k_nxt       = '0;
      ax_nxt      = {1'b0, rec.sx, {F{1'b0}}};
      ay_nxt      = {1'b0, rec.sy, {F{1'b0}}};
      stepx_nxt   = rec.stepx;
      stepy_nxt   = rec.stepy;
      ex_nxt      = rec.ex;
      ey_nxt      = rec.ey;
    end
    if (emit) begin
      oval_nxt  = 1'b1;
      px_nxt    = ax_r[AW-1] ? '0 : ax_r[F +: C];
      py_nxt    = ay_r[AW-1] ? '0 : ay_r[F +: C];
      last_nxt  = is_last;
      oclmp_nxt = clamped_r;
      k_nxt     = k_r + CW'(1);
      if (is_last) begin
        busy_nxt = 1'b0;
      end
      // a short segment jumps straight to its end point
      if (short_r) begin
        ax_nxt = {1'b0, ex_r, {F{1'b0}}};
        ay_nxt = {1'b0, ey_r, {F{1'b0}}};
      end else begin
        ax_nxt = ax_r + stepx_r;
        ay_nxt = ay_r + stepy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    short_r   <= short_nxt;
    clamped_r <= clamped_nxt;
    cnt_r     <= cnt_nxt;
    k_r       <= k_nxt;
    ax_r      <= ax_nxt;
    ay_r      <= ay_nxt;
    stepx_r   <= stepx_nxt;
    stepy_r   <= stepy_nxt;
    ex_r      <= ex_nxt;
    ey_r      <= ey_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    last_r    <= last_nxt;
    oclmp_r   <= oclmp_nxt;
  end

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    emit && is_last |=> !busy_r && oval_r && last_r)
    else $error("last point did not end the run");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> k_r < cnt_r)
    else $error("point index beyond count");

endmodule

// ===== hdl/line_segment_point_sampler_unit.sv =====
// top level of the line segment point sampler
`timescale 1ns / 1ps
// usage:
//   input channel: a segment (start_x/y, end_x/y) is taken when in_push is
//   high and in_full is low; in_full stays high while the front section
//   works on a segment.
//   result channel: while out_empty is low the oldest sample point is on the
//   out_ ports; it is taken when out_pop is high. out_last_point marks the
//   final point of a segment.
//   config channel: cfg_index 0 is sample_interval, 1 is pixel_pitch; writes
//   complete whenever cfg_valid is high (cfg_ready is always high).
// sequence: the front section forms the squared distance in the states DIFF,
//   SQ, SUM and TGT, then runs the count search through MUL1, MUL2 and CMP
//   for each count bit (7 bits by default), sets up in FIN, runs the
//   bit-serial step divider over COORD_BITS + FRAC_BITS quotient bits (28 by
//   default) and hands off in PUSH, which waits while the queue is full. A
//   segment shorter than one sample skips the divider. After loading a
//   record the back section emits one point per cycle while the result
//   register is empty or being popped; a two-entry queue lets both
//   sections run on different segments at once.
// stall: while out_pop is low the result register holds; the back section
//   and then the queue fill, and in_full stays high. reset clears all
//   control state and sets the registers to 100 and 25.

module line_segment_point_sampler_unit
  import lsps_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [COORD_BITS-1:0] out_point_x,
  output logic [COORD_BITS-1:0] out_point_y,
  output logic                  out_last_point,
  output logic                  out_count_clamped,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [IVL_W-1:0]      cfg_data
);

  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int AW    = COORD_BITS + FRAC_BITS + 1;
  localparam int REC_W = 2 + CW + 4 * COORD_BITS + 2 * AW;

  logic [IVL_W-1:0]   ivl_r, ivl_nxt;
  logic [PITCH_W-1:0] pitch_r, pitch_nxt;
  logic               q_push, q_full, q_pop, q_empty;
  logic [REC_W-1:0]   q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    ivl_nxt   = ivl_r;
    pitch_nxt = pitch_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAMPLE_INTERVAL: ivl_nxt = cfg_data;
        REG_PIXEL_PITCH:     pitch_nxt = cfg_data[PITCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivl_r   <= IVL_RST;
      pitch_r <= PITCH_RST;
    end else begin
      ivl_r   <= ivl_nxt;
      pitch_r <= pitch_nxt;
    end
  end

  lsps_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .sample_interval (ivl_r),
    .pixel_pitch     (pitch_r),
    .q_push          (q_push),
    .q_full          (q_full),
    .q_wdata         (q_wdata)
  );

  lsps_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  lsps_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rdata           (q_rdata),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_point_x       (out_point_x),
    .out_point_y       (out_point_y),
    .out_last_point    (out_last_point),
    .out_count_clamped (out_count_clamped)
  );

endmodule
